// ===== hw/rtl/bfed_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfed_pkg: shared types and constants of the flight event detector
// Register map, datapath command and status, sequencer codes, exp2 table.
// ----------------------------------------------------------------------------
package bfed_pkg;

  localparam int unsigned HIT_MARGIN_DEF = 5;
  localparam int unsigned HIT_W          = 3;

  localparam int unsigned DIV_NUM_W = 37;
  localparam int unsigned DIV_DEN_W = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam int unsigned LOG_STEPS   = 16;
  localparam int unsigned HORNER_LAST = 6;

  localparam logic [1:0] FUNC_MEASURE = 2'd0;
  localparam logic [1:0] FUNC_LAUNCH  = 2'd1;
  localparam logic [1:0] FUNC_APOGEE  = 2'd2;
  localparam logic [1:0] FUNC_LANDING = 2'd3;

  localparam logic [2:0] REG_GROUND_PRESSURE = 3'd0;
  localparam logic [2:0] REG_GROUND_TEMP     = 3'd1;
  localparam logic [2:0] REG_TEMP_GAIN       = 3'd2;
  localparam logic [2:0] REG_TEMP_OFFSET     = 3'd3;
  localparam logic [2:0] REG_ALPHA_ALT       = 3'd4;
  localparam logic [2:0] REG_ALPHA_SPEED     = 3'd5;

  localparam logic [16:0] GROUND_PRESSURE_RST = 17'd101325;
  localparam logic [13:0] GROUND_TEMP_RST     = 14'd1500;
  localparam logic [15:0] TEMP_GAIN_RST       = 16'd16384;
  localparam logic [11:0] TEMP_OFFSET_RST     = 12'd0;
  localparam logic [15:0] ALPHA_RST           = 16'd52429;

  typedef struct packed {
    logic        [16:0] ground_pressure;
    logic signed [13:0] ground_temp;
    logic        [15:0] temp_gain;
    logic signed [11:0] temp_offset;
    logic        [15:0] alpha_alt;
    logic        [15:0] alpha_speed;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_NORM, OP_LOG, OP_EXPY, OP_HORNER, OP_EXPFIN,
    OP_ALTMUL, OP_ALTSCL, OP_ALTRND, OP_ALTDIV, OP_EMA1, OP_EMA2, OP_EMA3,
    OP_SPDMUL, OP_SPDDIV, OP_SPDSAT, OP_COMMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_NORM, ST_LOG, ST_EXPY, ST_HORNER, ST_EXPFIN, ST_ALTMUL,
    ST_ALTSCL, ST_ALTRND, ST_ALTDIV, ST_EMA1, ST_EMA2, ST_EMA3, ST_SPDMUL,
    ST_SPDDIV, ST_SPDWAIT, ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic       spd_sel;
    logic [2:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_stat_t;

  // Taylor coefficients of 2^f in Q30
  function automatic logic [30:0] exp_coef(input logic [2:0] idx);
    logic [30:0] c;
    unique case (idx)
      3'd0: c = 31'd744261118;
      3'd1: c = 31'd257941248;
      3'd2: c = 31'd59597083;
      3'd3: c = 31'd10327388;
      3'd4: c = 31'd1431680;
      3'd5: c = 31'd165394;
      3'd6: c = 31'd16377;
      3'd7: c = 31'd1419;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] msb_pos(input logic [16:0] x);
    logic [4:0] k;
    k = '0;
    for (int i = 1; i < 17; i++) begin
      if (x[i]) k = 5'(i);
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bfed_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfed_div: restoring unsigned divider
// One quotient bit per cycle; done pulses with the quotient in place.
// ----------------------------------------------------------------------------
module bfed_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bfed_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [bfed_pkg::DIV_DEN_W-1:0] den_i,
  output logic                           done_o,
  output logic [bfed_pkg::DIV_NUM_W-1:0] quo_o
);
  import bfed_pkg::*;

  logic [DIV_DEN_W-1:0] rem_q, den_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_DEN_W:0]   sh, diff;
  logic                 ge;

  assign sh   = {rem_q, quo_q[DIV_NUM_W-1]};
  assign diff = sh - {1'b0, den_q};
  assign ge   = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DEN_W-1:0] : sh[DIV_DEN_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bfed_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfed_dp: flight event datapath
// Median, temperature, log2/exp2 altitude, EMA, speed, peaks and checks.
// ----------------------------------------------------------------------------
module bfed_dp #(
  parameter int unsigned HIT_MARGIN = bfed_pkg::HIT_MARGIN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bfed_pkg::cfg_t        cfg_i,
  input  bfed_pkg::dp_cmd_t     cmd_i,
  output bfed_pkg::dp_stat_t    stat_o,
  input  logic [1:0]            func_i,
  input  logic [16:0]           pressure_a_i,
  input  logic [16:0]           pressure_b_i,
  input  logic [16:0]           pressure_c_i,
  input  logic signed [14:0]    raw_temp_i,
  input  logic [31:0]           time_ms_i,
  input  logic                  cont_pin_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [16:0]           median_pressure_o,
  output logic signed [14:0]    temperature_o,
  output logic signed [24:0]    altitude_cm_o,
  output logic signed [20:0]    speed_cms_o,
  output logic signed [24:0]    apogee_cm_o,
  output logic signed [20:0]    max_speed_cms_o,
  output logic                  continuity_o,
  output logic                  event_found_o
);
  import bfed_pkg::*;

  function automatic logic [31:0] log_sq(input logic [30:0] m);
    logic [61:0] sq;
    sq = m * m;
    if (sq[61]) log_sq = {1'b1, sq[61:31]};
    else        log_sq = {1'b0, sq[60:30]};
  endfunction

  // item registers
  logic [1:0]         func_q;
  logic [16:0]        med_q;
  logic               cont_q;
  logic signed [31:0] tprod_q;
  logic [31:0]        dt_q;
  logic signed [14:0] temp_q;
  // log lanes: 0 median, 1 ground
  logic [4:0]         k0_q, k1_q;
  logic [30:0]        m0_q, m1_q;
  logic [15:0]        fr0_q, fr1_q;
  // exp2 and altitude
  logic signed [3:0]  n_q;
  logic [29:0]        f_q;
  logic [30:0]        acc_q;
  logic [35:0]        pw_q;
  logic signed [53:0] big_q;
  logic signed [63:0] num_q;
  logic [30:0]        q_q;
  logic               aneg_q;
  logic signed [24:0] newalt_q;
  // EMA and speed
  logic signed [41:0] eprod_q;
  logic signed [42:0] esum_q;
  logic signed [24:0] ema_q;
  logic signed [35:0] sn_q;
  logic               sneg_q;
  logic signed [20:0] spdraw_q;
  // flight state
  logic [31:0]        last_time_q;
  logic signed [24:0] alt_reg_q, apo_q;
  logic signed [20:0] spd_reg_q, maxs_q;
  logic [HIT_W-1:0]   hit_q;
  logic               out_valid_q;
  // result registers
  logic [16:0]        res_med_q;
  logic signed [14:0] res_temp_q;
  logic signed [24:0] res_alt_q, res_apo_q;
  logic signed [20:0] res_spd_q, res_maxs_q;
  logic               res_cont_q, res_found_q;

  // median of three
  logic [16:0] lo, hi, mm, med;
  assign lo  = (pressure_a_i < pressure_b_i) ? pressure_a_i : pressure_b_i;
  assign hi  = (pressure_a_i < pressure_b_i) ? pressure_b_i : pressure_a_i;
  assign mm  = (hi < pressure_c_i) ? hi : pressure_c_i;
  assign med = (lo > mm) ? lo : mm;

  logic signed [31:0] tprod_d;
  logic [31:0]        dtw;
  assign tprod_d = raw_temp_i * $signed({1'b0, cfg_i.temp_gain});
  assign dtw     = time_ms_i - last_time_q;

  // temperature rounding and clamp
  logic [31:0]        tmag, trl;
  logic signed [19:0] tsgn, tsum;
  logic signed [14:0] temp_d;
  always_comb begin
    tmag = tprod_q[31] ? 32'(-tprod_q) : 32'(tprod_q);
    trl  = tmag + 32'd8192;
    tsgn = tprod_q[31] ? -$signed({2'b0, trl[31:14]}) : $signed({2'b0, trl[31:14]});
    tsum = tsgn + 20'(cfg_i.temp_offset);
    if (tsum < -20'sd8000)      temp_d = -15'sd8000;
    else if (tsum > 20'sd16000) temp_d = 15'sd16000;
    else                        temp_d = tsum[14:0];
  end

  // normalize log operands
  logic [16:0] x0, x1;
  logic [4:0]  k0_d, k1_d;
  assign x0   = (med_q == '0) ? 17'd1 : med_q;
  assign x1   = (cfg_i.ground_pressure == '0) ? 17'd1 : cfg_i.ground_pressure;
  assign k0_d = msb_pos(x0);
  assign k1_d = msb_pos(x1);

  logic [31:0] ls0, ls1;
  assign ls0 = log_sq(m0_q);
  assign ls1 = log_sq(m1_q);

  // exponent y = d * 12472 in Q32
  logic signed [21:0] dlog;
  logic signed [36:0] yprod;
  assign dlog  = $signed({1'b0, k0_q, fr0_q}) - $signed({1'b0, k1_q, fr1_q});
  assign yprod = dlog * $signed(15'd12472);

  logic [60:0] hprod;
  logic [31:0] rexp;
  logic [39:0] pwl;
  logic [3:0]  nsh;
  logic [35:0] pw_d;
  assign hprod = acc_q * f_q;
  assign rexp  = 32'h4000_0000 + {1'b0, hprod[60:30]};
  assign nsh   = 4'(-n_q);
  assign pwl   = {8'b0, rexp} << n_q[2:0];
  assign pw_d  = n_q[3] ? 36'(rexp >> nsh) : pwl[35:0];

  // altitude = tc * (2^30 - pw) * 2000 / (13 * 2^30)
  logic signed [16:0] tc;
  logic signed [36:0] dif;
  logic signed [53:0] big_d;
  logic signed [63:0] bigx, num_d;
  logic [63:0]        nmag, qsum;
  logic [61:0]        qm;
  logic signed [28:0] qs;
  logic signed [24:0] newalt_d;
  always_comb begin
    tc    = 17'(cfg_i.ground_temp) + 17'sd27315;
    dif   = 37'sh0_4000_0000 - $signed({1'b0, pw_q});
    big_d = tc * dif;
    bigx  = 64'(big_q);
    num_d = (bigx <<< 11) - (bigx <<< 5) - (bigx <<< 4);
    nmag  = num_q[63] ? 64'(-num_q) : 64'(num_q);
    qsum  = nmag + 64'd6979321856;
    // divide by 13 through a reciprocal, exact for any 31-bit operand
    qm    = q_q * 31'd1321528399;
    qs    = aneg_q ? -$signed({1'b0, qm[61:34]}) : $signed({1'b0, qm[61:34]});
    if (qs < -29'sd1000000)      newalt_d = -25'sd1000000;
    else if (qs > 29'sd10000000) newalt_d = 25'sd10000000;
    else                         newalt_d = qs[24:0];
  end

  // shared EMA: weight of old value in Q0.16
  logic [15:0]        ema_w;
  logic [16:0]        winv;
  logic signed [24:0] ema_old, ema_new;
  logic signed [41:0] eprod_d;
  logic signed [42:0] esum_d;
  logic [42:0]        emag, erl;
  logic signed [24:0] ema_d;
  always_comb begin
    ema_w   = cmd_i.spd_sel ? cfg_i.alpha_speed : cfg_i.alpha_alt;
    ema_old = cmd_i.spd_sel ? 25'(spd_reg_q) : alt_reg_q;
    ema_new = cmd_i.spd_sel ? 25'(spdraw_q) : newalt_q;
    winv    = 17'h10000 - {1'b0, ema_w};
    eprod_d = $signed({1'b0, ema_w}) * ema_old;
    esum_d  = 43'(eprod_q) + ($signed({1'b0, winv}) * ema_new);
    emag    = esum_q[42] ? 43'(-esum_q) : 43'(esum_q);
    erl     = emag + 43'd32768;
    ema_d   = esum_q[42] ? -$signed(erl[40:16]) : $signed(erl[40:16]);
  end

  // speed numerator and clamp
  logic signed [25:0] ad;
  logic signed [35:0] adx, sn_d;
  logic [35:0]        smag;
  logic [36:0]        dnum;
  logic               div_done;
  logic [36:0]        div_quo;
  logic [19:0]        qclip;
  logic signed [20:0] spdraw_d;
  always_comb begin
    ad    = 26'(ema_q) - 26'(alt_reg_q);
    adx   = 36'(ad);
    sn_d  = (adx <<< 10) - (adx <<< 4) - (adx <<< 3);
    smag  = sn_q[35] ? 36'(-sn_q) : 36'(sn_q);
    dnum  = {1'b0, smag} + {6'b0, dt_q[31:1]};
    qclip = (div_quo > 37'd1000000) ? 20'd1000000 : div_quo[19:0];
    spdraw_d = sneg_q ? -$signed({1'b0, qclip}) : $signed({1'b0, qclip});
  end

  bfed_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.op == OP_SPDDIV),
    .num_i  (dnum),
    .den_i  (dt_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // peaks and debounced checks
  logic signed [20:0] spd_new, maxs_new;
  logic signed [24:0] apo_new;
  logic               hit, found;
  logic [HIT_W-1:0]   hit_inc, hit_d;
  always_comb begin
    spd_new  = ema_q[20:0];
    apo_new  = (apo_q < alt_reg_q) ? alt_reg_q : apo_q;
    maxs_new = (maxs_q < spd_new) ? spd_new : maxs_q;
    unique case (func_q)
      FUNC_LAUNCH:  hit = (alt_reg_q > 25'sd2000) && (spd_new > 21'sd100);
      FUNC_APOGEE:  hit = spd_new < 21'sd1000;
      FUNC_LANDING: hit = (spd_new > -21'sd200) && (spd_new < 21'sd200);
      default:      hit = 1'b0;
    endcase
    hit_inc = hit_q + 1'b1;
    found   = 1'b0;
    hit_d   = hit_q;
    if (func_q != FUNC_MEASURE) begin
      if (!hit) begin
        hit_d = '0;
      end else if (hit_inc >= HIT_W'(HIT_MARGIN)) begin
        hit_d = '0;
        found = 1'b1;
      end else begin
        hit_d = hit_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_time_q <= '0;
      alt_reg_q   <= '0;
      spd_reg_q   <= '0;
      apo_q       <= '0;
      maxs_q      <= '0;
      hit_q       <= '0;
    end else begin
      if (cmd_i.op == OP_COMMIT) out_valid_q <= 1'b1;
      else if (out_ready_i)      out_valid_q <= 1'b0;
      if (cmd_i.op == OP_LOAD) last_time_q <= time_ms_i;
      if (cmd_i.op == OP_SPDMUL) alt_reg_q <= ema_q;
      if (cmd_i.op == OP_COMMIT) begin
        spd_reg_q <= spd_new;
        apo_q     <= apo_new;
        maxs_q    <= maxs_new;
        hit_q     <= hit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        func_q  <= func_i;
        med_q   <= med;
        cont_q  <= ~cont_pin_i;
        tprod_q <= tprod_d;
        dt_q    <= (dtw == '0) ? 32'd1 : dtw;
      end
      OP_NORM: begin
        temp_q <= temp_d;
        k0_q   <= k0_d;
        k1_q   <= k1_d;
        m0_q   <= 31'(x0) << (5'd30 - k0_d);
        m1_q   <= 31'(x1) << (5'd30 - k1_d);
        fr0_q  <= '0;
        fr1_q  <= '0;
      end
      OP_LOG: begin
        m0_q  <= ls0[30:0];
        m1_q  <= ls1[30:0];
        fr0_q <= {fr0_q[14:0], ls0[31]};
        fr1_q <= {fr1_q[14:0], ls1[31]};
      end
      OP_EXPY: begin
        n_q   <= yprod[35:32];
        f_q   <= yprod[31:2];
        acc_q <= exp_coef(3'd7);
      end
      OP_HORNER: acc_q    <= exp_coef(cmd_i.idx) + hprod[60:30];
      OP_EXPFIN: pw_q     <= pw_d;
      OP_ALTMUL: big_q    <= big_d;
      OP_ALTSCL: num_q    <= num_d;
      OP_ALTRND: begin
        q_q    <= qsum[60:30];
        aneg_q <= num_q[63];
      end
      OP_ALTDIV: newalt_q <= newalt_d;
      OP_EMA1:   eprod_q  <= eprod_d;
      OP_EMA2:   esum_q   <= esum_d;
      OP_EMA3:   ema_q    <= ema_d;
      OP_SPDMUL: sn_q     <= sn_d;
      OP_SPDDIV: sneg_q   <= sn_q[35];
      OP_SPDSAT: spdraw_q <= spdraw_d;
      OP_COMMIT: begin
        res_med_q   <= med_q;
        res_temp_q  <= temp_q;
        res_alt_q   <= alt_reg_q;
        res_spd_q   <= spd_new;
        res_apo_q   <= apo_new;
        res_maxs_q  <= maxs_new;
        res_cont_q  <= cont_q;
        res_found_q <= found;
      end
      default: ;
    endcase
  end

  assign stat_o.div_done  = div_done;
  assign stat_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign median_pressure_o = res_med_q;
  assign temperature_o     = res_temp_q;
  assign altitude_cm_o     = res_alt_q;
  assign speed_cms_o       = res_spd_q;
  assign apogee_cm_o       = res_apo_q;
  assign max_speed_cms_o   = res_maxs_q;
  assign continuity_o      = res_cont_q;
  assign event_found_o     = res_found_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bfed_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfed_ctrl: sequencer of the flight event datapath
// Steps one item through log, exp, altitude, EMA and speed phases.
// ----------------------------------------------------------------------------
module bfed_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bfed_pkg::dp_stat_t  stat_i,
  output bfed_pkg::dp_cmd_t   cmd_o
);
  import bfed_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        spd_q, spd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      spd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      spd_q   <= spd_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    spd_d         = spd_q;
    in_ready_o    = 1'b0;
    cmd_o.op      = OP_NONE;
    cmd_o.spd_sel = spd_q;
    cmd_o.idx     = cnt_q[2:0];
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_NORM;
        end
      end
      ST_NORM: begin
        cmd_o.op = OP_NORM;
        cnt_d    = '0;
        state_d  = ST_LOG;
      end
      ST_LOG: begin
        cmd_o.op = OP_LOG;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == 4'(LOG_STEPS - 1)) state_d = ST_EXPY;
      end
      ST_EXPY: begin
        cmd_o.op = OP_EXPY;
        cnt_d    = 4'(HORNER_LAST);
        state_d  = ST_HORNER;
      end
      ST_HORNER: begin
        cmd_o.op = OP_HORNER;
        if (cnt_q == '0) state_d = ST_EXPFIN;
        else             cnt_d   = cnt_q - 1'b1;
      end
      ST_EXPFIN: begin
        cmd_o.op = OP_EXPFIN;
        state_d  = ST_ALTMUL;
      end
      ST_ALTMUL: begin
        cmd_o.op = OP_ALTMUL;
        state_d  = ST_ALTSCL;
      end
      ST_ALTSCL: begin
        cmd_o.op = OP_ALTSCL;
        state_d  = ST_ALTRND;
      end
      ST_ALTRND: begin
        cmd_o.op = OP_ALTRND;
        state_d  = ST_ALTDIV;
      end
      ST_ALTDIV: begin
        cmd_o.op = OP_ALTDIV;
        spd_d    = 1'b0;
        state_d  = ST_EMA1;
      end
      ST_EMA1: begin
        cmd_o.op = OP_EMA1;
        state_d  = ST_EMA2;
      end
      ST_EMA2: begin
        cmd_o.op = OP_EMA2;
        state_d  = ST_EMA3;
      end
      ST_EMA3: begin
        cmd_o.op = OP_EMA3;
        state_d  = spd_q ? ST_FINISH : ST_SPDMUL;
      end
      ST_SPDMUL: begin
        cmd_o.op = OP_SPDMUL;
        state_d  = ST_SPDDIV;
      end
      ST_SPDDIV: begin
        cmd_o.op = OP_SPDDIV;
        state_d  = ST_SPDWAIT;
      end
      ST_SPDWAIT: begin
        // clamp the raw speed, then run the speed pass of the EMA
        if (stat_i.div_done) begin
          cmd_o.op = OP_SPDSAT;
          spd_d    = 1'b1;
          state_d  = ST_EMA1;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (stat_i.out_free) begin
          cmd_o.op = OP_COMMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/barometric_flight_event_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barometric_flight_event_detector: barometric altimeter with event checks
// Median pressure, corrected temperature, smoothed altitude and speed,
// apogee and peak speed tracking, debounced launch/apogee/landing checks.
//
//   channel  dir  handshake               beat
//   in       in   in_valid_i / in_ready_o func, pressures, temp, time, pin
//   out      out  out_valid_o/out_ready_i one result per input beat
//   cfg      in   psel/penable/pwrite     six registers at 4*index
//
// One item is in flight at a time: the next is accepted only after the commit
// of the last. 16 log2 squarings (both operands in parallel lanes), 7 Horner
// steps and the 37-step speed divider dominate the run.
// Reset clears all flight state and loads the register defaults.
// A result waits in the output register; the next item is taken meanwhile
// and only its final commit stalls while the previous result is not taken.
// ----------------------------------------------------------------------------
module barometric_flight_event_detector #(
  parameter int unsigned HIT_MARGIN = bfed_pkg::HIT_MARGIN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [16:0]        pressure_a_i,
  input  logic [16:0]        pressure_b_i,
  input  logic [16:0]        pressure_c_i,
  input  logic signed [14:0] raw_temp_i,
  input  logic [31:0]        time_ms_i,
  input  logic               cont_pin_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [16:0]        median_pressure_o,
  output logic signed [14:0] temperature_o,
  output logic signed [24:0] altitude_cm_o,
  output logic signed [20:0] speed_cms_o,
  output logic signed [24:0] apogee_cm_o,
  output logic signed [20:0] max_speed_cms_o,
  output logic               continuity_o,
  output logic               event_found_o
);
  import bfed_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ground_pressure <= GROUND_PRESSURE_RST;
      cfg_q.ground_temp     <= GROUND_TEMP_RST;
      cfg_q.temp_gain       <= TEMP_GAIN_RST;
      cfg_q.temp_offset     <= TEMP_OFFSET_RST;
      cfg_q.alpha_alt       <= ALPHA_RST;
      cfg_q.alpha_speed     <= ALPHA_RST;
    end else if (wr_en) begin
      priority case (reg_idx)
        REG_GROUND_PRESSURE: cfg_q.ground_pressure <= pwdata[16:0];
        REG_GROUND_TEMP:     cfg_q.ground_temp     <= pwdata[13:0];
        REG_TEMP_GAIN:       cfg_q.temp_gain       <= pwdata[15:0];
        REG_TEMP_OFFSET:     cfg_q.temp_offset     <= pwdata[11:0];
        REG_ALPHA_ALT:       cfg_q.alpha_alt       <= pwdata[15:0];
        REG_ALPHA_SPEED:     cfg_q.alpha_speed     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority case (reg_idx)
      REG_GROUND_PRESSURE: prdata = {15'b0, cfg_q.ground_pressure};
      REG_GROUND_TEMP:     prdata = {18'b0, cfg_q.ground_temp};
      REG_TEMP_GAIN:       prdata = {16'b0, cfg_q.temp_gain};
      REG_TEMP_OFFSET:     prdata = {20'b0, cfg_q.temp_offset};
      REG_ALPHA_ALT:       prdata = {16'b0, cfg_q.alpha_alt};
      REG_ALPHA_SPEED:     prdata = {16'b0, cfg_q.alpha_speed};
      default:             prdata = '0;
    endcase
  end

  bfed_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  bfed_dp #(
    .HIT_MARGIN(HIT_MARGIN)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .func_i           (func_i),
    .pressure_a_i     (pressure_a_i),
    .pressure_b_i     (pressure_b_i),
    .pressure_c_i     (pressure_c_i),
    .raw_temp_i       (raw_temp_i),
    .time_ms_i        (time_ms_i),
    .cont_pin_i       (cont_pin_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .median_pressure_o(median_pressure_o),
    .temperature_o    (temperature_o),
    .altitude_cm_o    (altitude_cm_o),
    .speed_cms_o      (speed_cms_o),
    .apogee_cm_o      (apogee_cm_o),
    .max_speed_cms_o  (max_speed_cms_o),
    .continuity_o     (continuity_o),
    .event_found_o    (event_found_o)
  );

endmodule
`default_nettype wire
